// ===== hdl/fcs_pkg.sv =====
// Package with the types, codes and constants of the flash command snoop block.
`default_nettype none
package fcs_pkg;

    localparam int ADDR_BITS  = 21;
    localparam int COUNT_BITS = 24;
    localparam int DUR_BITS   = 24;
    localparam int WORD_BITS  = 16;
    localparam int CMD_BITS   = 8;

    localparam int IN_DATA_BITS  = 88;
    localparam int OUT_DATA_BITS = 40;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        SRC_FLASH  = 2'd0,
        SRC_RAW    = 2'd1,
        SRC_STATUS = 2'd2,
        SRC_NONE   = 2'd3
    } src_t;

    typedef enum logic [1:0] {
        REG_ENABLE   = 2'd0,
        REG_STATUS   = 2'd1,
        REG_DURATION = 2'd2
    } reg_index_t;

    localparam logic [CMD_BITS-1:0] CMD_LOCK_SETUP = 8'h60;
    localparam logic [CMD_BITS-1:0] CMD_SUSPEND    = 8'hb0;
    localparam logic [CMD_BITS-1:0] CMD_CONFIRM    = 8'hd0;
    localparam logic [CMD_BITS-1:0] CMD_ERASE      = 8'h20;
    localparam logic [CMD_BITS-1:0] CMD_PROGRAM    = 8'h40;
    localparam logic [CMD_BITS-1:0] CMD_LOCK_DOWN  = 8'h2f;
    localparam logic [CMD_BITS-1:0] CMD_LOCK_SET   = 8'h01;
    localparam logic [CMD_BITS-1:0] CMD_READ_ARRAY = 8'hff;
    localparam logic [CMD_BITS-1:0] CMD_RESET_ALT  = 8'hf0;

    localparam logic [WORD_BITS-1:0] WORD_LOCK_FWD    = 16'h0070;
    localparam logic [WORD_BITS-1:0] STATUS_SUSPENDED = 16'h00c0;
    localparam logic [WORD_BITS-1:0] STATUS_BUSY      = 16'h0000;
    localparam logic [WORD_BITS-1:0] STATUS_READY     = 16'h0080;

    localparam logic [DUR_BITS-1:0] DURATION_RESET = 24'd1000000;

    typedef struct packed {
        logic                 enabled;
        logic [ADDR_BITS-1:0] status_addr;
        logic [DUR_BITS-1:0]  duration;
    } cfg_t;

    typedef struct packed {
        logic                  lock_pending;
        logic                  program_pending;
        logic                  erase_confirm_pending;
        logic                  erase_busy;
        logic                  erase_paused;
        logic                  status_from_block;
        logic [COUNT_BITS-1:0] erase_remaining;
    } snoop_state_t;

    typedef struct packed {
        op_t                  operation;
        logic [ADDR_BITS-1:0] word_offset;
        logic [WORD_BITS-1:0] write_word;
        logic [WORD_BITS-1:0] lane_mask;
        logic [WORD_BITS-1:0] flash_read_word;
        logic [WORD_BITS-1:0] raw_array_word;
    } in_item_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] read_data;
        src_t                 read_source;
        logic                 forward_write;
        logic [WORD_BITS-1:0] forward_word;
    } out_item_t;

endpackage
`default_nettype wire

// ===== hdl/fcs_cfg.sv =====
// Configuration register file of the flash command snoop block.
`default_nettype none
module fcs_cfg
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    input  wire logic [1:0]                      cfg_index,
    input  wire logic [fcs_pkg::DUR_BITS-1:0]    cfg_data,
    output fcs_pkg::cfg_t                        cfg
);

    fcs_pkg::cfg_t cfg_reg;
    fcs_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                fcs_pkg::REG_ENABLE:
                    cfg_next.enabled = cfg_data[0];
                fcs_pkg::REG_STATUS:
                    cfg_next.status_addr = cfg_data[fcs_pkg::ADDR_BITS-1:0];
                fcs_pkg::REG_DURATION:
                    cfg_next.duration = cfg_data;
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled     <= 1'b1;
            cfg_reg.status_addr <= '0;
            cfg_reg.duration    <= fcs_pkg::DURATION_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== hdl/fcs_snoop.sv =====
// Command decode, status word and erase countdown for one item.
`default_nettype none
module fcs_snoop
(
    input  wire fcs_pkg::cfg_t         cfg,
    input  wire fcs_pkg::snoop_state_t state,
    input  wire fcs_pkg::in_item_t     item,
    output fcs_pkg::snoop_state_t      state_next,
    output fcs_pkg::out_item_t         result
);

    logic [fcs_pkg::CMD_BITS-1:0]   cmd;
    logic                           fwd;
    logic [fcs_pkg::WORD_BITS-1:0]  fwd_word;
    logic [fcs_pkg::WORD_BITS-1:0]  status_word;
    logic [fcs_pkg::COUNT_BITS-1:0] start_count;

    assign cmd = item.write_word[fcs_pkg::CMD_BITS-1:0];

    // The counter is as wide as the duration register, so no saturation is needed.
    assign start_count = (cfg.duration == '0) ? fcs_pkg::COUNT_BITS'(1)
                                              : fcs_pkg::COUNT_BITS'(cfg.duration);

    always_comb
    begin
        if (state.erase_paused)
            status_word = fcs_pkg::STATUS_SUSPENDED;
        else if (state.erase_busy)
            status_word = fcs_pkg::STATUS_BUSY;
        else
            status_word = fcs_pkg::STATUS_READY;
    end

    always_comb
    begin
        state_next = state;
        result     = '{read_data: '0, read_source: fcs_pkg::SRC_NONE,
                       forward_write: 1'b0, forward_word: '0};
        fwd        = 1'b1;
        fwd_word   = item.write_word;

        case (item.operation)
            fcs_pkg::OP_READ:
            begin
                if (!cfg.enabled || !state.status_from_block)
                begin
                    result.read_data   = item.flash_read_word & item.lane_mask;
                    result.read_source = fcs_pkg::SRC_FLASH;
                end
                else if (item.word_offset != cfg.status_addr)
                begin
                    result.read_data   = item.raw_array_word & item.lane_mask;
                    result.read_source = fcs_pkg::SRC_RAW;
                end
                else
                begin
                    result.read_data   = status_word & item.lane_mask;
                    result.read_source = fcs_pkg::SRC_STATUS;
                end
            end
            fcs_pkg::OP_WRITE:
            begin
                if (cfg.enabled)
                begin
                    if (state.program_pending)
                    begin
                        state_next.program_pending = 1'b0;
                    end
                    else if (state.lock_pending)
                    begin
                        state_next.lock_pending = 1'b0;
                        if (cmd inside {fcs_pkg::CMD_LOCK_SET, fcs_pkg::CMD_CONFIRM,
                                        fcs_pkg::CMD_LOCK_DOWN})
                            fwd_word = fcs_pkg::WORD_LOCK_FWD;
                    end
                    else if (cmd == fcs_pkg::CMD_LOCK_SETUP)
                    begin
                        state_next.lock_pending = 1'b1;
                        fwd = 1'b0;
                    end
                    else if (state.erase_busy && state.erase_paused
                             && cmd == fcs_pkg::CMD_CONFIRM)
                    begin
                        state_next.erase_paused      = 1'b0;
                        state_next.status_from_block = 1'b1;
                        if (state.erase_remaining == '0)
                            state_next.erase_remaining = fcs_pkg::COUNT_BITS'(1);
                        fwd = 1'b0;
                    end
                    else if (state.erase_busy && cmd == fcs_pkg::CMD_SUSPEND)
                    begin
                        // A second suspend leaves the frozen count alone.
                        if (state.erase_remaining == '0)
                            state_next.erase_remaining = fcs_pkg::COUNT_BITS'(1);
                        state_next.erase_paused      = 1'b1;
                        state_next.status_from_block = 1'b1;
                        fwd = 1'b0;
                    end
                    else if (cmd == fcs_pkg::CMD_ERASE)
                    begin
                        state_next.erase_confirm_pending = 1'b1;
                    end
                    else if (cmd == fcs_pkg::CMD_PROGRAM)
                    begin
                        state_next.program_pending = 1'b1;
                    end
                    else if (state.erase_confirm_pending)
                    begin
                        state_next.erase_confirm_pending = 1'b0;
                        if (cmd == fcs_pkg::CMD_CONFIRM)
                        begin
                            state_next.erase_busy        = 1'b1;
                            state_next.erase_paused      = 1'b0;
                            state_next.status_from_block = 1'b1;
                            state_next.erase_remaining   = start_count;
                        end
                    end

                    if (fwd && (cmd == fcs_pkg::CMD_READ_ARRAY
                                || cmd == fcs_pkg::CMD_RESET_ALT))
                        state_next.status_from_block = 1'b0;
                end
                result.forward_write = fwd;
                result.forward_word  = fwd ? fwd_word : '0;
            end
            fcs_pkg::OP_TICK:
            begin
                if (state.erase_busy && !state.erase_paused)
                begin
                    if (state.erase_remaining <= fcs_pkg::COUNT_BITS'(1))
                    begin
                        state_next.erase_busy      = 1'b0;
                        state_next.erase_paused    = 1'b0;
                        state_next.erase_remaining = '0;
                    end
                    else
                    begin
                        state_next.erase_remaining = state.erase_remaining
                                                     - fcs_pkg::COUNT_BITS'(1);
                    end
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/flash_command_snoop_erase_suspend_core.sv =====
// Top level of the flash command snoop block with erase suspend and resume.
// Each item (a bus read, a bus write or a one-microsecond tick) enters an input register,
// passes once through the command decode and countdown logic and lands in a result
// register, so the block takes one item per clock cycle unless m_axis_tready holds the
// result register full; a result is held in the result register once its item moves
// on from the input register. The single pass through that decode logic, which
// also updates the command and erase state, sets this rate. The input register takes a
// new item whenever the result register is empty or is being emptied in the same cycle.
// The configuration registers take effect for the next item and should only be written
// while no item is in flight. No clearing pass follows reset.
`default_nettype none
module flash_command_snoop_erase_suspend_core
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_axis_tvalid,
    output wire logic                                 s_axis_tready,
    // word_offset[20:0], write_word[36:21], lane_mask[52:37],
    // flash_read_word[68:53], raw_array_word[84:69], zero fill[87:85]
    input  wire logic [fcs_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
    // operation[1:0]
    input  wire logic [1:0]                           s_axis_tuser,
    output wire logic                                 m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // read_data[15:0], forward_write[16], forward_word[32:17], zero fill[39:33]
    output wire logic [fcs_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
    // read_source[1:0]
    output wire logic [1:0]                           m_axis_tuser,
    input  wire logic                                 cfg_valid,
    output wire logic                                 cfg_ready,
    input  wire logic [1:0]                           cfg_index,
    input  wire logic [fcs_pkg::DUR_BITS-1:0]         cfg_data
);

    fcs_pkg::cfg_t         cfg;
    fcs_pkg::snoop_state_t state_reg;
    fcs_pkg::snoop_state_t state_next;
    fcs_pkg::in_item_t     in_item_reg;
    fcs_pkg::in_item_t     in_item_next;
    fcs_pkg::out_item_t    out_item_reg;
    fcs_pkg::out_item_t    out_item_next;
    logic                  in_valid_reg;
    logic                  out_valid_reg;
    logic                  advance;
    logic                  in_take;

    assign cfg_ready = 1'b1;

    fcs_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // An item moves to the result register when that register is free or being taken.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign in_item_next.operation       = fcs_pkg::op_t'(s_axis_tuser);
    assign in_item_next.word_offset     = s_axis_tdata[20:0];
    assign in_item_next.write_word      = s_axis_tdata[36:21];
    assign in_item_next.lane_mask       = s_axis_tdata[52:37];
    assign in_item_next.flash_read_word = s_axis_tdata[68:53];
    assign in_item_next.raw_array_word  = s_axis_tdata[84:69];

    fcs_snoop u_snoop
    (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .result     (out_item_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_item_reg <= in_item_next;
        if (advance)
            out_item_reg <= out_item_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_item_reg.forward_word, out_item_reg.forward_write,
                            out_item_reg.read_data};
    assign m_axis_tuser  = out_item_reg.read_source;

    a_paused_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.erase_paused |-> state_reg.erase_busy)
        else $error("erase paused while no erase is running");

    a_busy_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.erase_busy |-> (state_reg.erase_remaining != '0))
        else $error("erase running with a zero remaining count");

    a_no_fwd_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_item_reg.forward_write) |-> (out_item_reg.forward_word == '0))
        else $error("forward word set on a result that forwards nothing");

    a_none_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.read_source == fcs_pkg::SRC_NONE)
        |-> (out_item_reg.read_data == '0))
        else $error("read data set on a result that is not a read");

endmodule
`default_nettype wire
